### src/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int QW          = $clog2(QUEUE_DEPTH);

    localparam logic [QW-1:0] RING_LAST = QW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SCROLL = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [1:0] REG_FOUR_BYTE = 2'd0;
    localparam logic [1:0] REG_COLUMNS   = 2'd1;
    localparam logic [1:0] REG_ROWS      = 2'd2;

    localparam int         SYNC_BIT      = 3;
    localparam logic [7:0] OVF_MASK      = 8'hC0;
    localparam logic [7:0] BTN_MASK      = 8'h07;

    // divide by ten as multiply by 205 / 2048, exact for the 8-bit magnitudes used
    localparam logic [7:0] SCALE         = 8'd10;
    localparam logic [7:0] RECIP         = 8'd205;
    localparam int         RECIP_SHIFT   = 11;

    localparam logic signed [8:0] SCROLL_MAX = 9'sd127;
    localparam logic signed [8:0] SCROLL_MIN = -9'sd127;

    localparam logic       FOUR_BYTE_RST = 1'b1;
    localparam logic [6:0] COLUMNS_RST   = 7'd80;
    localparam logic [4:0] ROWS_RST      = 5'd25;
    localparam logic [6:0] COL_RST       = 7'd40;
    localparam logic [4:0] ROW_RST       = 5'd12;

    typedef struct packed {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [2:0]        buttons;
        logic [2:0]        flags;
        logic signed [7:0] wheel;
        logic [31:0]       sequence_no;
    } ev_t;

    typedef struct packed {
        logic signed [4:0] res_x;
        logic signed [4:0] res_y;
        logic [6:0]        col;
        logic [4:0]        row;
    } motion_t;

    typedef struct packed {
        logic              ok;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [2:0]        buttons;
        logic [2:0]        flags;
        logic signed [7:0] wheel;
        logic [31:0]       sequence_no;
        logic [6:0]        px;
        logic [4:0]        py;
        logic signed [7:0] scroll;
        logic [2:0]        cur_buttons;
    } result_t;

    function automatic logic [QW-1:0] ring_inc(input logic [QW-1:0] idx);
        return (idx == RING_LAST) ? '0 : idx + QW'(1);
    endfunction

endpackage

`default_nettype wire

### src/pmt_in_if.sv
// ----------------------------------------------------------------------------
// pmt_in_if
// Input channel: action code and raw aux-port byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] aux_byte;

    modport source (output valid, output action, output aux_byte, input ready);
    modport sink   (input valid, input action, input aux_byte, output ready);
endinterface

`default_nettype wire

### src/pmt_out_if.sv
// ----------------------------------------------------------------------------
// pmt_out_if
// Result channel: popped event, cursor, scroll total and button state.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmt_out_if;
    logic              valid;
    logic              ready;
    logic              ok;
    logic signed [7:0] event_dx;
    logic signed [7:0] event_dy;
    logic [2:0]        event_buttons;
    logic [2:0]        event_flags;
    logic signed [7:0] event_wheel;
    logic [31:0]       event_sequence;
    logic [6:0]        pointer_x;
    logic [4:0]        pointer_y;
    logic signed [7:0] scroll_amount;
    logic [2:0]        current_buttons;

    modport source (
        output valid, output ok, output event_dx, output event_dy,
        output event_buttons, output event_flags, output event_wheel,
        output event_sequence, output pointer_x, output pointer_y,
        output scroll_amount, output current_buttons, input ready
    );
    modport sink (
        input valid, input ok, input event_dx, input event_dy,
        input event_buttons, input event_flags, input event_wheel,
        input event_sequence, input pointer_x, input pointer_y,
        input scroll_amount, input current_buttons, output ready
    );
endinterface

`default_nettype wire

### src/pmt_motion.sv
// ----------------------------------------------------------------------------
// pmt_motion
// Cursor update: residual accumulate, truncating divide by ten, Y inverted,
// clamp to screen.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_motion
    import pmt_pkg::*;
(
    input  wire logic signed [7:0] dx,
    input  wire logic signed [7:0] dy,
    input  wire motion_t           cur,
    input  wire logic [6:0]        columns,
    input  wire logic [4:0]        rows,
    output motion_t                nxt
);

    logic signed [8:0] rx, ry;
    logic [7:0]        mag_x, mag_y;
    logic [15:0]       prod_x, prod_y;
    logic [3:0]        q_x, q_y;
    logic [3:0]        rem_x, rem_y;
    logic signed [4:0] sx, sy;
    logic signed [8:0] col_sum;
    logic signed [7:0] row_sum;
    logic [6:0]        col_top;
    logic [4:0]        row_top;

    always_comb
    begin
        rx     = {dx[7], dx} + {{4{cur.res_x[4]}}, cur.res_x};
        ry     = {dy[7], dy} + {{4{cur.res_y[4]}}, cur.res_y};
        mag_x  = rx[8] ? 8'(-rx) : rx[7:0];
        mag_y  = ry[8] ? 8'(-ry) : ry[7:0];
        prod_x = 16'(mag_x) * 16'(RECIP);
        prod_y = 16'(mag_y) * 16'(RECIP);
        q_x    = 4'(prod_x >> RECIP_SHIFT);
        q_y    = 4'(prod_y >> RECIP_SHIFT);
        rem_x  = 4'(mag_x - 8'(8'(q_x) * SCALE));
        rem_y  = 4'(mag_y - 8'(8'(q_y) * SCALE));
        sx     = rx[8] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        sy     = ry[8] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});

        nxt.res_x = rx[8] ? -$signed({1'b0, rem_x}) : $signed({1'b0, rem_x});
        nxt.res_y = ry[8] ? -$signed({1'b0, rem_y}) : $signed({1'b0, rem_y});

        col_top = (columns == 7'd0) ? 7'd0 : columns - 7'd1;
        row_top = (rows == 5'd0) ? 5'd0 : rows - 5'd1;

        col_sum = $signed({2'b00, cur.col}) + {{4{sx[4]}}, sx};
        row_sum = $signed({3'b000, cur.row}) - {{3{sy[4]}}, sy};

        if (col_sum[8])
            nxt.col = 7'd0;
        else if (col_sum[7:0] > {1'b0, col_top})
            nxt.col = col_top;
        else
            nxt.col = col_sum[6:0];

        if (row_sum[7])
            nxt.row = 5'd0;
        else if (row_sum[6:0] > {2'b00, row_top})
            nxt.row = row_top;
        else
            nxt.row = row_sum[4:0];
    end

endmodule

`default_nettype wire

### src/ps2_mouse_packet_tracker.sv
// Latency: a pop or scroll read is registered in s1, then in the output stage;
// aux bytes give no result. Throughput: one item per cycle unless stalled, set
// by the single pass from state registers to the event ring write and its
// registered read. A stalled result is held in a second stage so one more item
// is still taken. Reset clears control state and config to defaults at once;
// the event ring and packet bytes are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Assembles PS/2 mouse packets, queues events, tracks cursor and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker
    import pmt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    pmt_in_if.sink          item,
    pmt_out_if.source       result,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_data
);

    logic          four_byte_reg;
    logic [6:0]    columns_reg;
    logic [4:0]    rows_reg;

    logic [1:0]    pos_reg, pos_next;
    logic [7:0]    pkt0_reg, pkt1_reg, pkt2_reg;
    motion_t       motion_reg, motion_next, motion_calc;
    logic [2:0]    held_reg, held_next;
    logic signed [7:0] scroll_reg, scroll_next;
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [31:0]   count_reg, count_next;

    ev_t           ring_mem [QUEUE_DEPTH];
    ev_t           rdata_reg;
    ev_t           new_ev;

    logic          s1_valid_reg, s1_valid_next;
    logic          s1_ok_reg, s1_event_reg;
    logic [6:0]    s1_x_reg;
    logic [4:0]    s1_y_reg;
    logic signed [7:0] s1_scroll_reg;
    logic [2:0]    s1_btn_reg;

    logic          out_valid_reg, out_valid_next;
    result_t       out_reg;

    logic          acc, is_byte, is_pop, is_scroll, has_result;
    logic          start_ok, last, push;
    logic signed [7:0] dx, dy, wheel;
    logic [2:0]    buttons;
    logic signed [8:0] scroll_sum;
    logic          s1_move;
    action_t       act;

    assign act        = action_t'(item.action);
    assign item.ready = !s1_valid_reg || !out_valid_reg || result.ready;
    assign acc        = item.valid && item.ready;
    assign is_byte    = acc && (act == ACT_BYTE);
    assign is_pop     = acc && (act == ACT_POP);
    assign is_scroll  = acc && (act == ACT_SCROLL);
    assign has_result = is_pop || is_scroll;
    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);

    assign start_ok = (pos_reg != 2'd0) || item.aux_byte[SYNC_BIT];
    assign last     = four_byte_reg ? (pos_reg == 2'd3) : (pos_reg >= 2'd2);
    assign push     = is_byte && start_ok && last && ((pkt0_reg & OVF_MASK) == 8'h00);

    assign dx      = pkt1_reg;
    assign dy      = (pos_reg == 2'd2) ? item.aux_byte : pkt2_reg;
    assign wheel   = four_byte_reg ? item.aux_byte : 8'sd0;
    assign buttons = 3'(pkt0_reg & BTN_MASK);

    pmt_motion u_motion (
        .dx      (dx),
        .dy      (dy),
        .cur     (motion_reg),
        .columns (columns_reg),
        .rows    (rows_reg),
        .nxt     (motion_calc)
    );

    always_comb
    begin
        new_ev.dx          = dx;
        new_ev.dy          = dy;
        new_ev.buttons     = buttons;
        new_ev.flags       = {wheel != 8'sd0, buttons != held_reg,
                              (dx != 8'sd0) || (dy != 8'sd0)};
        new_ev.wheel       = wheel;
        new_ev.sequence_no = count_reg;
        scroll_sum         = {scroll_reg[7], scroll_reg} + {wheel[7], wheel};
    end

    always_comb
    begin
        pos_next    = pos_reg;
        motion_next = motion_reg;
        held_next   = held_reg;
        scroll_next = scroll_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;

        if (is_byte && start_ok)
            pos_next = last ? 2'd0 : pos_reg + 2'd1;

        if (push)
        begin
            head_next   = ring_inc(head_reg);
            if (ring_inc(head_reg) == tail_reg)
                tail_next = ring_inc(tail_reg);
            count_next  = count_reg + 32'd1;
            held_next   = buttons;
            motion_next = motion_calc;
            if (scroll_sum > SCROLL_MAX)
                scroll_next = 8'(SCROLL_MAX);
            else if (scroll_sum < SCROLL_MIN)
                scroll_next = 8'(SCROLL_MIN);
            else
                scroll_next = scroll_sum[7:0];
        end

        if (is_pop && (head_reg != tail_reg))
            tail_next = ring_inc(tail_reg);

        if (is_scroll)
            scroll_next = 8'sd0;

        if (has_result)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_byte_reg <= FOUR_BYTE_RST;
            columns_reg   <= COLUMNS_RST;
            rows_reg      <= ROWS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FOUR_BYTE: four_byte_reg <= cfg_data[0];
                REG_COLUMNS:   columns_reg   <= cfg_data;
                REG_ROWS:      rows_reg      <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            motion_reg    <= '{res_x: 5'sd0, res_y: 5'sd0, col: COL_RST, row: ROW_RST};
            held_reg      <= 3'd0;
            scroll_reg    <= 8'sd0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= 32'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            motion_reg    <= motion_next;
            held_reg      <= held_next;
            scroll_reg    <= scroll_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_byte && start_ok)
        begin
            case (pos_reg)
                2'd0:    pkt0_reg <= item.aux_byte;
                2'd1:    pkt1_reg <= item.aux_byte;
                2'd2:    pkt2_reg <= item.aux_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ring_mem[head_reg] <= new_ev;
        if (is_pop)
            rdata_reg <= ring_mem[tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            s1_ok_reg     <= is_scroll || (head_reg != tail_reg);
            s1_event_reg  <= is_pop && (head_reg != tail_reg);
            s1_x_reg      <= motion_reg.col;
            s1_y_reg      <= motion_reg.row;
            s1_scroll_reg <= is_scroll ? scroll_reg : 8'sd0;
            s1_btn_reg    <= held_reg;
        end
        if (s1_move)
        begin
            out_reg.ok          <= s1_ok_reg;
            out_reg.dx          <= s1_event_reg ? rdata_reg.dx : 8'sd0;
            out_reg.dy          <= s1_event_reg ? rdata_reg.dy : 8'sd0;
            out_reg.buttons     <= s1_event_reg ? rdata_reg.buttons : 3'd0;
            out_reg.flags       <= s1_event_reg ? rdata_reg.flags : 3'd0;
            out_reg.wheel       <= s1_event_reg ? rdata_reg.wheel : 8'sd0;
            out_reg.sequence_no <= s1_event_reg ? rdata_reg.sequence_no : 32'd0;
            out_reg.px          <= s1_x_reg;
            out_reg.py          <= s1_y_reg;
            out_reg.scroll      <= s1_scroll_reg;
            out_reg.cur_buttons <= s1_btn_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.ok              = out_reg.ok;
    assign result.event_dx        = out_reg.dx;
    assign result.event_dy        = out_reg.dy;
    assign result.event_buttons   = out_reg.buttons;
    assign result.event_flags     = out_reg.flags;
    assign result.event_wheel     = out_reg.wheel;
    assign result.event_sequence  = out_reg.sequence_no;
    assign result.pointer_x       = out_reg.px;
    assign result.pointer_y       = out_reg.py;
    assign result.scroll_amount   = out_reg.scroll;
    assign result.current_buttons = out_reg.cur_buttons;

    // a push never leaves the ring looking empty
    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (head_reg != tail_reg))
        else $error("ring empty after push");

    a_residual_range: assert property (@(posedge clk) disable iff (!rst_n)
        (motion_reg.res_x >= -5'sd9) && (motion_reg.res_x <= 5'sd9) &&
        (motion_reg.res_y >= -5'sd9) && (motion_reg.res_y <= 5'sd9))
        else $error("cursor residual out of range");

    a_scroll_sat: assert property (@(posedge clk) disable iff (!rst_n)
        scroll_reg != 8'sh80)
        else $error("scroll total beyond saturation");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("transfer taken with both result stages full");

    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        (is_pop && (head_reg != tail_reg)) |=> (tail_reg != $past(tail_reg)))
        else $error("pop did not advance tail");

endmodule

`default_nettype wire
